/* sv/gsa_pkg.sv */
// Shared types and codes for the generational slot allocator.
// Holds the request and response words, the slot entry layout and the status codes.
// No dependencies.
package gsa_pkg;

	// Default pool size and fixed field widths.
	localparam int POOL_SLOTS_DEF = 64;
	localparam int IDX_W = 6;
	localparam int GEN_W = 32;

	// Operation codes carried in the kind field.
	localparam logic [1:0] KIND_ACQUIRE  = 2'd0;
	localparam logic [1:0] KIND_RELEASE  = 2'd1;
	localparam logic [1:0] KIND_VALIDATE = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_FULL  = 3'd1;
	localparam logic [2:0] ST_RANGE = 3'd2;
	localparam logic [2:0] ST_STALE = 3'd3;
	localparam logic [2:0] ST_FREE  = 3'd4;

	// One request word.
	typedef struct packed {
		logic [1:0]       kind;
		logic [IDX_W-1:0] slot_index;
		logic [GEN_W-1:0] handle_generation;
	} req_t;

	// One response word.
	typedef struct packed {
		logic [2:0]       status;
		logic [IDX_W-1:0] granted_slot;
		logic [GEN_W-1:0] granted_generation;
	} rsp_t;

	// Per-slot entry: in-use mark and current generation.
	typedef struct packed {
		logic             busy;
		logic [GEN_W-1:0] gen;
	} slot_entry_t;

	// Write strobes from the decision logic to the slot and link memories.
	typedef struct packed {
		logic entry_we;
		logic link_we;
	} wr_ctl_t;

endpackage

/* sv/gsa_ram.sv */
// Simple dual-port memory with one write port and one registered read port.
// A read of the address being written in the same cycle returns the new data.
// Depends on nothing.
module gsa_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 33
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write-first storage: the read register sees a same-cycle write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

endmodule

/* sv/gsa_core.sv */
// Decision logic and list registers of the generational slot allocator.
// Holds the free-list head and the count of opened slots, decides each word.
// Depends on gsa_pkg.
module gsa_core import gsa_pkg::*; #(
	parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  req_t                          req,
	input  slot_entry_t                   entry_rd,
	input  logic [$clog2(POOL_SLOTS):0]   link_rd,
	output rsp_t                          result,
	output wr_ctl_t                       wr,
	output logic [$clog2(POOL_SLOTS)-1:0] waddr,
	output slot_entry_t                   wentry,
	output logic [$clog2(POOL_SLOTS):0]   wlink,
	output logic [$clog2(POOL_SLOTS)-1:0] head_nxt
);

	localparam int SW = $clog2(POOL_SLOTS);
	localparam int OW = $clog2(POOL_SLOTS + 1);

	logic          head_vld_q, head_vld_d;
	logic [SW-1:0] head_q, head_d;
	logic [OW-1:0] opened_q, opened_d;
	logic          idx_ok;
	wr_ctl_t       wr_c;

	// A slot index is addressable only once that slot has been opened.
	assign idx_ok = 32'(req.slot_index) < 32'(opened_q);

	// Decide the response and the state change for the word in stage one.
	always_comb begin
		result = '{status: ST_OK, granted_slot: req.slot_index, granted_generation: '0};
		wr_c = '0;
		waddr = SW'(req.slot_index);
		wentry = '{busy: 1'b0, gen: entry_rd.gen};
		wlink = {head_vld_q, head_q};
		head_vld_d = head_vld_q;
		head_d = head_q;
		opened_d = opened_q;
		case (req.kind)
			KIND_ACQUIRE: begin
				if (head_vld_q) begin
					// Pop the free list; the link entry names the next head.
					wr_c.entry_we = 1'b1;
					waddr = head_q;
					wentry = '{busy: 1'b1, gen: entry_rd.gen};
					head_vld_d = link_rd[SW];
					head_d = link_rd[SW-1:0];
					result.granted_slot = IDX_W'(head_q);
					result.granted_generation = entry_rd.gen;
				end else if (32'(opened_q) < POOL_SLOTS) begin
					// Open a fresh slot at generation zero.
					wr_c.entry_we = 1'b1;
					waddr = SW'(opened_q);
					wentry = '{busy: 1'b1, gen: '0};
					opened_d = opened_q + OW'(1);
					result.granted_slot = IDX_W'(opened_q);
				end else begin
					result.status = ST_FULL;
				end
			end
			KIND_RELEASE: begin
				if (!idx_ok) begin
					result.status = ST_RANGE;
				end else if (!entry_rd.busy) begin
					result.status = ST_FREE;
					result.granted_generation = entry_rd.gen;
				end else begin
					// Bump the generation and push the slot on the free list.
					wr_c.entry_we = 1'b1;
					wr_c.link_we = 1'b1;
					wentry = '{busy: 1'b0, gen: entry_rd.gen + 32'd1};
					head_vld_d = 1'b1;
					head_d = SW'(req.slot_index);
					result.granted_generation = entry_rd.gen + 32'd1;
				end
			end
			KIND_VALIDATE: begin
				if (!idx_ok) begin
					result.status = ST_RANGE;
				end else begin
					result.granted_generation = entry_rd.gen;
					if (req.handle_generation != entry_rd.gen) begin
						result.status = ST_STALE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Memory writes and the next read address follow only a word that moves on.
	assign wr = fire ? wr_c : '0;
	assign head_nxt = fire ? head_d : head_q;

	// List head and opened-slot count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			head_q <= '0;
			opened_q <= '0;
		end else if (fire) begin
			head_vld_q <= head_vld_d;
			head_q <= head_d;
			opened_q <= opened_d;
		end
	end

endmodule

/* sv/generational_slot_allocator.sv */
// Top level of the generational slot allocator: handshake, pipeline and memories.
// Instantiates gsa_ram (slot entries and free-list links) and gsa_core.
// Depends on gsa_pkg.
//
//   channel   valid      stall      word       direction
//   request   req_valid  req_stall  req_word   into the block
//   response  rsp_valid  rsp_stall  rsp_word   out of the block
//
// One word is accepted per cycle while req_stall is low; its response is valid once the word
// has passed stage one and the result register. Acceptance loads stage one together with
// the registered read of the slot and link memories; stage one moving on loads the result
// register. Reset empties the free list and the opened-slot count; the memories are not
// cleared, since a slot is written when it is opened.
// A stalled response holds the result register, and stage one then stalls requests.
module generational_slot_allocator import gsa_pkg::*; #(
	parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_word,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_word
);

	localparam int SW = $clog2(POOL_SLOTS);

	logic          vld_s1;
	req_t          req_s1;
	logic          rsp_vld_q;
	rsp_t          rsp_q;
	logic          accept, fire, out_free;
	logic [SW-1:0] raddr, waddr, head_nxt;
	logic [SW:0]   link_rd, wlink;
	logic [$bits(slot_entry_t)-1:0] entry_bits;
	slot_entry_t   entry_rd, wentry;
	rsp_t          result;
	wr_ctl_t       wr;

	// Handshake: stage one moves on when the result register is empty or taken.
	assign out_free = !rsp_vld_q || !rsp_stall;
	assign fire = vld_s1 && out_free;
	assign req_stall = vld_s1 && !out_free;
	assign accept = req_valid && !req_stall;

	// An acquire reads at the list head as it stands after the word ahead of it.
	assign raddr = (req_word.kind == KIND_ACQUIRE) ? head_nxt : SW'(req_word.slot_index);

	gsa_ram #(
		.DEPTH(POOL_SLOTS),
		.WIDTH($bits(slot_entry_t))
	) u_entry_ram (
		.clk(clk),
		.we(wr.entry_we),
		.waddr(waddr),
		.wdata(wentry),
		.re(accept),
		.raddr(raddr),
		.rdata(entry_bits)
	);

	assign entry_rd = slot_entry_t'(entry_bits);

	gsa_ram #(
		.DEPTH(POOL_SLOTS),
		.WIDTH(SW + 1)
	) u_link_ram (
		.clk(clk),
		.we(wr.link_we),
		.waddr(waddr),
		.wdata(wlink),
		.re(accept),
		.raddr(raddr),
		.rdata(link_rd)
	);

	gsa_core #(
		.POOL_SLOTS(POOL_SLOTS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.req(req_s1),
		.entry_rd(entry_rd),
		.link_rd(link_rd),
		.result(result),
		.wr(wr),
		.waddr(waddr),
		.wentry(wentry),
		.wlink(wlink),
		.head_nxt(head_nxt)
	);

	// Stage one: the accepted request word, beside the memory read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_word;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (out_free) begin
			rsp_vld_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp_word = rsp_q;

	// Memories are written only by a word that leaves stage one.
	a_write_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.entry_we || wr.link_we) |-> fire)
		else $error("memory write without a word leaving stage one");

	// Only a successful release pushes onto the free list.
	a_link_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		wr.link_we |-> (req_s1.kind == KIND_RELEASE && result.status == ST_OK))
		else $error("free-list link written outside a successful release");

	// A word leaving stage one is in the result register at the next edge.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_vld_q)
		else $error("result lost between stage one and the result register");

endmodule
